FILE: rtl/afd_pkg.sv
`default_nettype none

package afd_pkg;

   localparam logic [7:0]  StartByte     = 8'h7E;
   localparam logic [7:0]  DefaultRxType = 8'h90;
   localparam logic [15:0] MinLength     = 16'd12;
   localparam logic [16:0] PayloadOffset = 17'd15;
   localparam logic [16:0] TypeOffset    = 17'd3;
   localparam int          IndexWidth    = 17;

   typedef enum logic [1:0] {
      PH_WAIT   = 2'd0,
      PH_LENGTH = 2'd1,
      PH_BODY   = 2'd2
   } phase_type;

   typedef enum logic {
      KIND_PAYLOAD = 1'b0,
      KIND_END     = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
      logic       last;
   } result_type;

endpackage

`default_nettype wire

FILE: rtl/api_frame_rx_deframer_top.sv
`default_nettype none

// Receive-side API frame parser. Each received serial byte is one word on the
// req_ stream; the block hunts for the 0x7E start byte, reads a big-endian
// 16-bit length and the frame type, and for frames whose type matches the
// csr_ register (reset 0x90) and whose length is at least 12 sends every byte
// from frame offset 15 up to the checksum as a payload word, the final one
// marked by rsp_tlast. The checksum byte then leaves as an end-of-message word
// (rsp_tuser high); it is not verified. Other frames produce no output. Every
// byte is parsed in the cycle it is accepted, so the block takes one byte per
// clock; results pass through a two-entry output buffer, and req_tready falls
// only while both entries hold words that the downstream side has not taken.
// Result words are registered in the output buffer before they reach the rsp_ stream.
module api_frame_rx_deframer_top (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_wr_en,
   input  wire logic [7:0] csr_wr_data,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] rx_byte
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [7:0] data_byte
   output logic            rsp_tuser,   // [0] result_kind
   output logic            rsp_tlast    // last_payload
);
   import afd_pkg::*;

   logic       accept;
   logic       space;
   logic       res_valid;
   result_type res;
   result_type out_word;

   assign req_tready = space;
   assign accept     = req_tvalid && space;

   afd_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .byte_valid  (accept),
      .byte_data   (req_tdata),
      .res         (res),
      .res_valid   (res_valid)
   );

   afd_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .space     (space),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_word)
   );

   assign rsp_tdata = out_word.data;
   assign rsp_tuser = out_word.kind;
   assign rsp_tlast = out_word.last;

endmodule

`default_nettype wire

FILE: rtl/afd_parser.sv
`default_nettype none

module afd_parser (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_wr_en,
   input  wire logic [7:0]         csr_wr_data,
   input  wire logic               byte_valid,
   input  wire logic [7:0]         byte_data,
   output afd_pkg::result_type     res,
   output logic                    res_valid
);
   import afd_pkg::*;

   phase_type                phase_ff, phase_in;
   logic [IndexWidth-1:0]    index_ff, index_in;
   logic [15:0]              length_ff, length_in;
   logic [7:0]               length_high_ff, length_high_in;
   logic [7:0]               kind_ff, kind_in;
   logic [7:0]               rx_type_ff;

   logic [7:0]               kind_now;
   logic [IndexWidth-1:0]    length_ext;
   logic                     match;
   logic                     at_end;
   logic                     in_payload;
   logic                     at_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_type_ff <= DefaultRxType;
      end else if (csr_wr_en) begin
         rx_type_ff <= csr_wr_data;
      end
   end

   // The type byte sits at offset 3 and must already count for that byte.
   assign kind_now   = (index_ff == TypeOffset) ? byte_data : kind_ff;
   assign length_ext = {1'b0, length_ff};
   assign match      = (kind_now == rx_type_ff) && (length_ff >= MinLength);
   assign at_end     = (index_ff == length_ext + 17'd3);
   assign at_last    = (index_ff == length_ext + 17'd2);
   assign in_payload = (index_ff >= PayloadOffset) && (index_ff <= length_ext + 17'd2);

   always_comb begin
      phase_in       = phase_ff;
      index_in       = index_ff;
      length_in      = length_ff;
      length_high_in = length_high_ff;
      kind_in        = kind_ff;
      if (byte_valid) begin
         unique case (phase_ff)
            PH_LENGTH: begin
               if (index_ff == 17'd1) begin
                  length_high_in = byte_data;
                  index_in       = 17'd2;
               end else begin
                  length_in = {length_high_ff, byte_data};
                  index_in  = 17'd3;
                  phase_in  = PH_BODY;
               end
            end
            PH_BODY: begin
               kind_in  = kind_now;
               index_in = index_ff + 17'd1;
               if (at_end) begin
                  phase_in = PH_WAIT;
                  index_in = '0;
               end
            end
            default: begin
               if (byte_data == StartByte) begin
                  index_in = 17'd1;
                  phase_in = PH_LENGTH;
               end
            end
         endcase
      end
   end

   always_comb begin
      res_valid = 1'b0;
      res.kind  = KIND_PAYLOAD;
      res.data  = byte_data;
      res.last  = 1'b0;
      if (byte_valid && phase_ff == PH_BODY && match) begin
         if (at_end) begin
            res_valid = 1'b1;
            res.kind  = KIND_END;
         end else if (in_payload) begin
            res_valid = 1'b1;
            res.last  = at_last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_WAIT;
         index_ff       <= '0;
         length_ff      <= '0;
         length_high_ff <= '0;
         kind_ff        <= '0;
      end else begin
         phase_ff       <= phase_in;
         index_ff       <= index_in;
         length_ff      <= length_in;
         length_high_ff <= length_high_in;
         kind_ff        <= kind_in;
      end
   end

   a_res_in_body: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> phase_ff == PH_BODY)
      else $error("result outside of a frame body");

   a_end_closes: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res.kind == KIND_END) |=> (phase_ff == PH_WAIT && index_ff == '0))
      else $error("end of message did not close the frame");

   a_last_is_payload: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res.last) |-> (res.kind == KIND_PAYLOAD && index_ff >= PayloadOffset))
      else $error("last flag on a word that is not payload");

endmodule

`default_nettype wire

FILE: rtl/afd_skid.sv
`default_nettype none

module afd_skid (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           push,
   input  afd_pkg::result_type push_data,
   output logic                space,
   output logic                out_valid,
   input  wire logic           out_ready,
   output afd_pkg::result_type out_data
);
   import afd_pkg::*;

   result_type  entry_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        pop;

   assign space     = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2)
      else $error("output buffer count out of range");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != 2'd2 || pop))
      else $error("word written into a full output buffer");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + 2'd1)
      else $error("output buffer lost a word");

endmodule

`default_nettype wire
